// File: rtl/riot_pkg.sv
// shared types and constants for the ram, i/o and interval timer unit
`default_nettype none

package riot_pkg;

	typedef enum logic [2:0] {
		FUNC_READ   = 3'd0,
		FUNC_WRITE  = 3'd1,
		FUNC_TICK   = 3'd2,
		FUNC_JOY    = 3'd3,
		FUNC_SWITCH = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RAM_RD,
		ST_TICK,
		ST_HOLD
	} state_t;

	localparam int unsigned ADDR_W     = 8;
	localparam int unsigned DATA_W     = 8;
	localparam int unsigned RAM_AW     = 7;
	localparam int unsigned RAM_DEPTH  = 128;
	localparam int unsigned PSC_W      = 11;
	localparam int unsigned CYC_W      = 4;

	localparam logic [4:0] WR_PORT_A   = 5'h00;
	localparam logic [4:0] WR_PORT_B   = 5'h02;
	localparam logic [4:0] WR_TIM_LO   = 5'h14;
	localparam logic [4:0] WR_TIM_HI   = 5'h17;

	localparam logic [2:0] RD_PORT_A   = 3'd0;
	localparam logic [2:0] RD_DDR_A    = 3'd1;
	localparam logic [2:0] RD_PORT_B   = 3'd2;
	localparam logic [2:0] RD_DDR_B    = 3'd3;
	localparam logic [2:0] RD_TIM_0    = 3'd4;
	localparam logic [2:0] RD_FLAG_0   = 3'd5;
	localparam logic [2:0] RD_TIM_1    = 3'd6;
	localparam logic [2:0] RD_FLAG_1   = 3'd7;

	localparam logic [DATA_W-1:0] PORT_A_RST = 8'hFF;
	localparam logic [DATA_W-1:0] PORT_B_RST = 8'h0B;
	localparam logic [DATA_W-1:0] TIMER_RST  = 8'hFF;
	localparam logic [1:0]        PSC_RST    = 2'd3;

	typedef struct packed {
		logic              load;
		logic [DATA_W-1:0] data;
		logic [1:0]        sel;
		logic              add;
		logic [CYC_W-1:0]  cycles;
		logic              run;
	} timer_cmd_t;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              flag;
		logic              more;
	} timer_stat_t;

endpackage

`default_nettype wire

// File: rtl/riot_ram.sv
// 128-byte synchronous ram with per-entry valid bits cleared at reset
`default_nettype none

module riot_ram (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          we,
	input  wire logic [riot_pkg::RAM_AW-1:0]   waddr,
	input  wire logic [riot_pkg::DATA_W-1:0]   wdata,
	input  wire logic                          re,
	input  wire logic [riot_pkg::RAM_AW-1:0]   raddr,
	output logic      [riot_pkg::DATA_W-1:0]   rdata
);

	logic [riot_pkg::DATA_W-1:0]    mem [riot_pkg::RAM_DEPTH];
	logic [riot_pkg::RAM_DEPTH-1:0] vld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= vld_q[raddr] ? mem[raddr] : '0;
		end
	end

endmodule

`default_nettype wire

// File: rtl/riot_timer.sv
// interval timer with prescaler, stepped once per cycle while a tick drains
`default_nettype none

module riot_timer (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire riot_pkg::timer_cmd_t cmd,
	output riot_pkg::timer_stat_t     stat
);

	logic [riot_pkg::DATA_W-1:0] value_q;
	logic [1:0]                  sel_q;
	logic [riot_pkg::PSC_W-1:0]  count_q;
	logic                        flag_q;
	logic [riot_pkg::PSC_W-1:0]  step;
	logic                        more;

	always_comb begin
		case (sel_q)
			2'd0:    step = riot_pkg::PSC_W'(1);
			2'd1:    step = riot_pkg::PSC_W'(8);
			2'd2:    step = riot_pkg::PSC_W'(64);
			default: step = riot_pkg::PSC_W'(1024);
		endcase
	end

	assign more = (count_q >= step);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= riot_pkg::TIMER_RST;
			sel_q   <= riot_pkg::PSC_RST;
			count_q <= '0;
			flag_q  <= 1'b0;
		end else if (cmd.load) begin
			value_q <= cmd.data;
			sel_q   <= cmd.sel;
			count_q <= '0;
			flag_q  <= 1'b0;
		end else if (cmd.add) begin
			count_q <= count_q + riot_pkg::PSC_W'(cmd.cycles);
		end else if (cmd.run && more) begin
			count_q <= count_q - step;
			if (value_q == '0) begin
				value_q <= '1;
				flag_q  <= 1'b1;
			end else begin
				value_q <= value_q - riot_pkg::DATA_W'(1);
			end
		end
	end

	assign stat.value = value_q;
	assign stat.flag  = flag_q;
	assign stat.more  = more;

endmodule

`default_nettype wire

// File: rtl/riot_ram_io_interval_timer_unit.sv
// top level: request decode, port registers, ram and timer sequencing
//
// one request enters on the s_ channel: s_tuser carries the function code,
// s_tdata the address, write byte, cycle count, joysticks and switches.
// every request gives exactly one result byte on the m_ channel, in order.
// register reads, writes, joystick and switch updates finish in the cycle
// they are taken; a ram read finishes in the ST_RAM_RD state, once the
// registered read port of the ram holds the byte. a clock tick first adds
// the cycle count to the prescaler, then makes each timer decrement of the
// timer unit in ST_TICK, at most 15, and ends when no decrement is left.
// the result sits in an output register; while it waits for m_tready one
// more request is taken and worked, and its result is held until the
// output register frees, during which s_tready stays low.
// reset clears the ram (through valid bits, at once), sets the ports,
// timer and prescaler to their power-up values and empties the output.
`default_nettype none

module riot_ram_io_interval_timer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// reg_addr[7:0], write_data[15:8], cycle_count[19:16], joy_one[27:20],
	// joy_two[35:28], rst_sw[36], sel_sw[37], zeros[39:38]
	input  wire logic [39:0] s_tdata,
	// func[2:0]
	input  wire logic [2:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// read_data[7:0]
	output logic [7:0]       m_tdata
);

	riot_pkg::state_t      state_q, state_d;
	riot_pkg::func_t       func;
	riot_pkg::timer_cmd_t  tcmd;
	riot_pkg::timer_stat_t tstat;

	logic [riot_pkg::ADDR_W-1:0] reg_addr;
	logic [riot_pkg::DATA_W-1:0] write_data;
	logic [riot_pkg::CYC_W-1:0]  cycle_count;
	logic [7:0]                  joy_one, joy_two;
	logic                        rst_sw, sel_sw;

	logic [riot_pkg::DATA_W-1:0] port_a_q, port_b_q, res_q, m_tdata_q;
	logic                        m_tvalid_q;
	logic [riot_pkg::DATA_W-1:0] ram_rdata, reg_rdata, fin_data;
	logic                        accept, out_free, fin;
	logic                        is_ram_rd, is_tick, is_wr, ram_we, tim_ld;
	logic [4:0]                  wsel;

	assign reg_addr    = s_tdata[7:0];
	assign write_data  = s_tdata[15:8];
	assign cycle_count = s_tdata[19:16];
	assign joy_one     = s_tdata[27:20];
	assign joy_two     = s_tdata[35:28];
	assign rst_sw      = s_tdata[36];
	assign sel_sw      = s_tdata[37];
	assign func        = riot_pkg::func_t'(s_tuser);

	assign s_tready = (state_q == riot_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign is_ram_rd = (func == riot_pkg::FUNC_READ) && reg_addr[7];
	assign is_tick   = (func == riot_pkg::FUNC_TICK);
	assign is_wr     = accept && (func == riot_pkg::FUNC_WRITE);
	assign wsel      = reg_addr[4:0];
	assign ram_we    = is_wr && reg_addr[7];
	assign tim_ld    = is_wr && !reg_addr[7] && (wsel inside {[riot_pkg::WR_TIM_LO :
		riot_pkg::WR_TIM_HI]});

	riot_ram u_ram (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (ram_we),
		.waddr (reg_addr[riot_pkg::RAM_AW-1:0]),
		.wdata (write_data),
		.re    (accept && is_ram_rd),
		.raddr (reg_addr[riot_pkg::RAM_AW-1:0]),
		.rdata (ram_rdata)
	);

	always_comb begin
		tcmd.load   = tim_ld;
		tcmd.data   = write_data;
		tcmd.sel    = wsel[1:0];
		tcmd.add    = accept && is_tick;
		tcmd.cycles = cycle_count;
		tcmd.run    = (state_q == riot_pkg::ST_TICK);
	end

	riot_timer u_timer (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (tcmd),
		.stat  (tstat)
	);

	// register reads below the ram window
	always_comb begin
		case (reg_addr[2:0])
			riot_pkg::RD_PORT_A: reg_rdata = port_a_q;
			riot_pkg::RD_PORT_B: reg_rdata = port_b_q;
			riot_pkg::RD_DDR_A, riot_pkg::RD_DDR_B: reg_rdata = '1;
			riot_pkg::RD_TIM_0, riot_pkg::RD_TIM_1: begin
				reg_rdata = tstat.value;
				if (tstat.value == '0 || tstat.flag) begin
					reg_rdata[7] = 1'b1;
				end
			end
			riot_pkg::RD_FLAG_0, riot_pkg::RD_FLAG_1:
				reg_rdata = {tstat.flag, 7'b0};
			default: reg_rdata = '1;
		endcase
	end

	// completion of the current request
	always_comb begin
		fin      = 1'b0;
		fin_data = '0;
		case (state_q)
			riot_pkg::ST_IDLE: begin
				fin = accept && !is_ram_rd && !is_tick;
				if (func == riot_pkg::FUNC_READ) begin
					fin_data = reg_rdata;
				end
			end
			riot_pkg::ST_RAM_RD: begin
				fin      = 1'b1;
				fin_data = ram_rdata;
			end
			riot_pkg::ST_TICK: begin
				fin = !tstat.more;
			end
			riot_pkg::ST_HOLD: begin
				fin      = 1'b1;
				fin_data = res_q;
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		if (fin) begin
			state_d = out_free ? riot_pkg::ST_IDLE : riot_pkg::ST_HOLD;
		end else if (accept && is_ram_rd) begin
			state_d = riot_pkg::ST_RAM_RD;
		end else if (accept && is_tick) begin
			state_d = riot_pkg::ST_TICK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= riot_pkg::ST_IDLE;
			m_tvalid_q <= 1'b0;
			port_a_q   <= riot_pkg::PORT_A_RST;
			port_b_q   <= riot_pkg::PORT_B_RST;
		end else begin
			state_q <= state_d;
			if (out_free) begin
				m_tvalid_q <= fin;
			end
			if (is_wr && !reg_addr[7] && wsel == riot_pkg::WR_PORT_A) begin
				port_a_q <= write_data;
			end else if (accept && func == riot_pkg::FUNC_JOY) begin
				port_a_q <= ~{joy_one[1], joy_one[2], joy_one[3], joy_one[4],
					joy_two[1], joy_two[2], joy_two[3], joy_two[4]};
			end
			if (is_wr && !reg_addr[7] && wsel == riot_pkg::WR_PORT_B) begin
				port_b_q <= write_data;
			end else if (accept && func == riot_pkg::FUNC_SWITCH) begin
				// reset switch is not wired to port b
				port_b_q <= {4'b0000, 1'b1, rst_sw & 1'b0, sel_sw, 1'b1};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin && out_free) begin
			m_tdata_q <= fin_data;
		end
		if (fin && !out_free) begin
			res_q <= fin_data;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// testbench for the ram, i/o and interval timer unit with its own prediction of every result
`timescale 1ns / 100ps

module tb_top;
	import riot_pkg::*;

	localparam logic [2:0] FUNC_RSVD_5 = 3'd5;
	localparam logic [2:0] FUNC_RSVD_6 = 3'd6;
	localparam logic [2:0] FUNC_RSVD_7 = 3'd7;
	localparam logic [7:0] RAM_BASE    = 8'h80;
	localparam int unsigned N_RANDOM   = 1125;
	localparam int unsigned LONG_HOLD  = 70;
	localparam int unsigned WDOG_LIMIT = 5000;

	typedef struct {
		logic [2:0] func;
		logic [7:0] addr;
		logic [7:0] wdata;
		logic [3:0] cyc;
		logic [7:0] joy1;
		logic [7:0] joy2;
		logic       rst_sw;
		logic       sel_sw;
		bit         drain_first;
	} req_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;
	logic [2:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;

	riot_ram_io_interval_timer_unit u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial forever #2 clk = ~clk;

	// predicted state of the unit
	logic [7:0]       ram_mem [RAM_DEPTH];
	logic [7:0]       porta;
	logic [7:0]       portb;
	logic [7:0]       tmr;
	logic [1:0]       psc_sel;
	logic [PSC_W-1:0] psc_cnt;
	logic             uflag;

	req_t       pend_q[$];
	logic [7:0] read_data_q[$];
	req_t       cur_req;
	logic [7:0] want_rd;

	int unsigned n_errors   = 0;
	int unsigned n_accepted = 0;
	int unsigned n_results  = 0;
	int unsigned n_reads    = 0;
	int unsigned n_ram_rd   = 0;
	int unsigned n_writes   = 0;
	int unsigned n_ticks    = 0;
	int unsigned n_wraps    = 0;
	int unsigned n_other    = 0;

	function automatic void model_reset();
		foreach (ram_mem[i]) ram_mem[i] = 8'h00;
		porta   = PORT_A_RST;
		portb   = PORT_B_RST;
		tmr     = TIMER_RST;
		psc_sel = PSC_RST;
		psc_cnt = '0;
		uflag   = 1'b0;
	endfunction

	function automatic logic [7:0] model_read(logic [7:0] a);
		if (a >= RAM_BASE) begin
			n_ram_rd++;
			return ram_mem[a[6:0]];
		end
		case (a[2:0])
			RD_PORT_A: return porta;
			RD_PORT_B: return portb;
			RD_TIM_0, RD_TIM_1: return (tmr == 8'h00 || uflag) ? (tmr | 8'h80) : tmr;
			RD_FLAG_0, RD_FLAG_1: return uflag ? 8'h80 : 8'h00;
			default: return 8'hFF;
		endcase
	endfunction

	function automatic void model_write(logic [7:0] a, logic [7:0] d);
		logic [4:0] sel;
		sel = a[4:0];
		if (a >= RAM_BASE) begin
			ram_mem[a[6:0]] = d;
		end else if (sel == WR_PORT_A) begin
			porta = d;
		end else if (sel == WR_PORT_B) begin
			portb = d;
		end else if (sel >= WR_TIM_LO && sel <= WR_TIM_HI) begin
			tmr     = d;
			psc_sel = 2'(sel - WR_TIM_LO);
			uflag   = 1'b0;
			psc_cnt = '0;
		end
	endfunction

	function automatic void model_tick(logic [3:0] cyc);
		int unsigned step;
		int unsigned cnt;
		case (psc_sel)
			2'd0: step = 1;
			2'd1: step = 8;
			2'd2: step = 64;
			default: step = 1024;
		endcase
		cnt = (int'(psc_cnt) + int'(cyc)) & 32'h7FF;
		while (cnt >= step) begin
			cnt -= step;
			if (tmr == 8'h00) begin
				uflag = 1'b1;
				tmr   = 8'hFF;
				n_wraps++;
			end else begin
				tmr = tmr - 8'd1;
			end
		end
		psc_cnt = PSC_W'(cnt);
	endfunction

	function automatic logic [7:0] predict_read_data(req_t r);
		logic [7:0] rd;
		rd = 8'h00;
		case (r.func)
			FUNC_READ: begin
				n_reads++;
				rd = model_read(r.addr);
			end
			FUNC_WRITE: begin
				n_writes++;
				model_write(r.addr, r.wdata);
			end
			FUNC_TICK: begin
				n_ticks++;
				model_tick(r.cyc);
			end
			FUNC_JOY: begin
				n_other++;
				porta = ~{r.joy1[1], r.joy1[2], r.joy1[3], r.joy1[4],
					r.joy2[1], r.joy2[2], r.joy2[3], r.joy2[4]};
			end
			FUNC_SWITCH: begin
				n_other++;
				portb = 8'h09 | {6'b0, r.sel_sw, 1'b0};
			end
			default: n_other++;
		endcase
		return rd;
	endfunction

	function automatic req_t mk(logic [2:0] f, logic [7:0] a, logic [7:0] d, logic [3:0] c,
		logic [7:0] j1, logic [7:0] j2, logic rs, logic ss);
		req_t r;
		r.func = f; r.addr = a; r.wdata = d; r.cyc = c;
		r.joy1 = j1; r.joy2 = j2; r.rst_sw = rs; r.sel_sw = ss;
		r.drain_first = 1'b0;
		return r;
	endfunction

	function automatic req_t rand_req();
		req_t r;
		int unsigned k;
		r = mk(3'($urandom), 8'($urandom), 8'($urandom), 4'($urandom),
			8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
		k = $urandom_range(99);
		if (k < 30)      r.func = FUNC_READ;
		else if (k < 55) r.func = FUNC_WRITE;
		else if (k < 78) r.func = FUNC_TICK;
		else if (k < 86) r.func = FUNC_JOY;
		else if (k < 94) r.func = FUNC_SWITCH;
		else             r.func = 3'($urandom_range(FUNC_RSVD_5, FUNC_RSVD_7));
		if ($urandom_range(1) == 0) begin
			r.addr = {1'b1, 7'($urandom)};
		end else if (r.func == FUNC_WRITE) begin
			k = $urandom_range(9);
			r.addr = {1'b0, 7'($urandom)};
			if (k < 2) begin
				r.addr[4:0] = WR_PORT_A;
			end else if (k < 4) begin
				r.addr[4:0] = WR_PORT_B;
			end else if (k < 8) begin
				r.addr[4:0] = WR_TIM_LO + 5'($urandom_range(3));
				if ($urandom_range(1) == 0) r.wdata = 8'($urandom_range(4));
			end
		end else begin
			r.addr = {1'b0, 7'($urandom)};
		end
		return r;
	endfunction

	// stimulus and end of run
	initial begin
		req_t r;
		model_reset();
		pend_q.push_back(mk(FUNC_READ,   8'h00, 8'h3C, 4'h0, 8'h00, 8'h00, 1'b0, 1'b0));
		pend_q.push_back(mk(FUNC_READ,   8'h02, 8'h00, 4'hF, 8'hFF, 8'hFF, 1'b1, 1'b1));
		pend_q.push_back(mk(FUNC_READ,   8'h04, 8'h00, 4'h0, 8'h00, 8'h00, 1'b0, 1'b0));
		pend_q.push_back(mk(FUNC_READ,   8'h80, 8'hFF, 4'h0, 8'h00, 8'h00, 1'b0, 1'b0));
		pend_q.push_back(mk(FUNC_WRITE,  8'h80, 8'hA5, 4'h0, 8'h00, 8'h00, 1'b0, 1'b0));
		pend_q.push_back(mk(FUNC_WRITE,  8'hFF, 8'h5A, 4'h0, 8'h00, 8'h00, 1'b0, 1'b0));
		pend_q.push_back(mk(FUNC_READ,   8'hFF, 8'h00, 4'h0, 8'h00, 8'h00, 1'b0, 1'b0));
		pend_q.push_back(mk(FUNC_READ,   8'h80, 8'h00, 4'h0, 8'h00, 8'h00, 1'b0, 1'b0));
		pend_q.push_back(mk(FUNC_WRITE,  8'h01, 8'h33, 4'h0, 8'h00, 8'h00, 1'b0, 1'b0));
		pend_q.push_back(mk(FUNC_READ,   8'h7B, 8'h00, 4'h0, 8'h00, 8'h00, 1'b0, 1'b0));
		pend_q.push_back(mk(FUNC_WRITE,  8'h14, 8'h01, 4'h0, 8'h00, 8'h00, 1'b0, 1'b0));
		pend_q.push_back(mk(FUNC_TICK,   8'h00, 8'h00, 4'h0, 8'h00, 8'h00, 1'b0, 1'b0));
		pend_q.push_back(mk(FUNC_TICK,   8'h00, 8'h00, 4'h1, 8'h00, 8'h00, 1'b0, 1'b0));
		pend_q.push_back(mk(FUNC_READ,   8'h06, 8'h00, 4'h0, 8'h00, 8'h00, 1'b0, 1'b0));
		pend_q.push_back(mk(FUNC_TICK,   8'h00, 8'h00, 4'hF, 8'h00, 8'h00, 1'b0, 1'b0));
		pend_q.push_back(mk(FUNC_READ,   8'h7F, 8'h00, 4'h0, 8'h00, 8'h00, 1'b0, 1'b0));
		r = mk(FUNC_WRITE, 8'h77, 8'h00, 4'h0, 8'h00, 8'h00, 1'b0, 1'b0);
		r.drain_first = 1'b1;
		pend_q.push_back(r);
		pend_q.push_back(mk(FUNC_JOY,    8'h00, 8'h00, 4'h0, 8'hFF, 8'h00, 1'b0, 1'b0));
		pend_q.push_back(mk(FUNC_JOY,    8'h00, 8'h00, 4'h0, 8'h00, 8'hFF, 1'b0, 1'b0));
		pend_q.push_back(mk(FUNC_SWITCH, 8'h00, 8'h00, 4'h0, 8'h00, 8'h00, 1'b0, 1'b1));
		pend_q.push_back(mk(FUNC_SWITCH, 8'h00, 8'h00, 4'h0, 8'h00, 8'h00, 1'b1, 1'b0));
		pend_q.push_back(mk(FUNC_WRITE,  8'h60, 8'h00, 4'h0, 8'h00, 8'h00, 1'b0, 1'b0));
		pend_q.push_back(mk(FUNC_RSVD_5, 8'h00, 8'hFF, 4'hF, 8'hFF, 8'hFF, 1'b1, 1'b1));
		pend_q.push_back(mk(FUNC_RSVD_6, 8'h02, 8'h00, 4'h0, 8'h00, 8'h00, 1'b0, 1'b0));
		pend_q.push_back(mk(FUNC_RSVD_7, 8'h00, 8'h00, 4'h0, 8'h00, 8'h00, 1'b0, 1'b0));
		for (int unsigned i = 0; i < N_RANDOM; i++) begin
			r = rand_req();
			r.drain_first = (i == 400 || i == 900);
			pend_q.push_back(r);
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pend_q.size() != 0 || s_tvalid || read_data_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("run covered %0d requests: %0d reads (%0d from ram), %0d writes, %0d ticks",
			n_accepted, n_reads, n_ram_rd, n_writes, n_ticks);
		$display("timer wrapped %0d times; %0d port updates or ignored codes; %0d results checked",
			n_wraps, n_other, n_results);
		if (n_errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// request driver, bursts with random gaps
	int unsigned burst_left;
	int unsigned gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= '0;
			s_tuser    <= '0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				read_data_q.push_back(predict_read_data(cur_req));
				n_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pend_q.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (pend_q[0].drain_first && (read_data_q.size() != 0 ||
					(s_tvalid && s_tready))) begin
					s_tvalid <= 1'b0;
				end else begin
					cur_req  = pend_q.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= cur_req.func;
					s_tdata  <= {2'b00, cur_req.sel_sw, cur_req.rst_sw, cur_req.joy2,
						cur_req.joy1, cur_req.cyc, cur_req.wdata, cur_req.addr};
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left--;
					end
				end
			end
		end
	end

	// result ready pattern with two long hold-offs
	int unsigned hold_left;
	int unsigned holds_done;
	int unsigned rdy_mode;
	int unsigned rdy_cycles;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			hold_left  = 0;
			holds_done = 0;
			rdy_mode   = 0;
			rdy_cycles = 0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if ((holds_done == 0 && n_accepted >= 250) ||
			(holds_done == 1 && n_accepted >= 700)) begin
			holds_done++;
			hold_left = LONG_HOLD;
			m_tready <= 1'b0;
		end else begin
			if (rdy_cycles == 0) begin
				rdy_cycles = $urandom_range(20, 80);
				rdy_mode   = $urandom_range(3);
			end else begin
				rdy_cycles--;
			end
			case (rdy_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(3) != 0);
				2: m_tready <= ($urandom_range(3) == 0);
				default: m_tready <= ~m_tready;
			endcase
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			n_results++;
			if (read_data_q.size() == 0) begin
				$error("unexpected result, read_data actual %02h", m_tdata);
				n_errors++;
			end else begin
				want_rd = read_data_q.pop_front();
				if (m_tdata !== want_rd) begin
					$error("read_data mismatch: expected %02h actual %02h", want_rd, m_tdata);
					n_errors++;
				end
			end
		end
	end

	// watchdog on cycles with no request or result moving
	int unsigned idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

endmodule
